### hw/rtl/tga_rle_pixel_decoder_assert.svh
// assertion macros for the tga rle pixel decoder
`ifndef TGA_RLE_PIXEL_DECODER_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_ASSERT_SVH

// checked only outside reset
`define TGA_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TGA_ASSERT_ALL(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hw/rtl/tgarle_pkg.sv
package tgarle_pkg;

    localparam int BYTE_W  = 8;
    localparam int PIXEL_W = 32;
    localparam int REP_W   = 8;
    localparam int COUNT_W = 31;
    localparam int BPP_W   = 3;

    // configuration register indexes
    localparam logic [1:0] CFG_BPP   = 2'd0;
    localparam logic [1:0] CFG_TOTAL = 2'd1;
    localparam logic [1:0] CFG_RLE   = 2'd2;

    localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd4;
    localparam logic [COUNT_W-1:0] TOTAL_RESET = 31'd1;
    localparam logic               RLE_RESET   = 1'b1;

    // packet header: bit 7 flags a run, low seven bits hold count - 1
    localparam int               RUN_BIT  = 7;
    localparam logic [6:0]       LEN_MASK = 7'd127;

    typedef struct packed {
        logic [BPP_W-1:0]   bpp;
        logic [COUNT_W-1:0] total;
        logic               rle;
    } t_cfg;

    typedef struct packed {
        logic               in_header;
        logic               is_run;
        logic [REP_W-1:0]   pkt_left;
        logic [PIXEL_W-1:0] gather;
        logic [1:0]         byte_idx;
        logic [COUNT_W-1:0] written;
        logic               finished;
    } t_state;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic [REP_W-1:0]   repeat_res;
        logic               image_done;
    } t_result;

    localparam t_state STATE_RESET = '{
        in_header: 1'b1,
        is_run:    1'b0,
        pkt_left:  '0,
        gather:    '0,
        byte_idx:  '0,
        written:   '0,
        finished:  1'b0
    };

    function automatic logic [BPP_W-1:0] eff_bpp(input logic [BPP_W-1:0] bpp);
        logic [BPP_W-1:0] r;
        r = bpp;
        if (bpp == 3'd0) r = 3'd1;
        else if (bpp > 3'd4) r = 3'd4;
        return r;
    endfunction

endpackage

### hw/rtl/tgarle_step.sv
module tgarle_step (
    input  tgarle_pkg::t_cfg    i_cfg,
    input  tgarle_pkg::t_state  i_state,
    input  logic [7:0]          i_byte,
    input  logic                i_first,
    output tgarle_pkg::t_state  o_state,
    output logic                o_res_valid,
    output tgarle_pkg::t_result o_res
);
    import tgarle_pkg::*;

    t_state             st;
    logic [BPP_W-1:0]   bpp;
    logic [PIXEL_W-1:0] gath;
    logic [PIXEL_W-1:0] px;
    logic [REP_W-1:0]   rep;
    logic [REP_W-1:0]   left_new;
    logic [COUNT_W-1:0] remain;
    logic [COUNT_W-1:0] written_new;
    logic               blocked;
    logic               last_byte;
    logic               done;

    always_comb begin
        // a first byte restarts the image before the byte itself is used
        st  = i_first ? STATE_RESET : i_state;
        bpp = eff_bpp(i_cfg.bpp);
        blocked   = st.finished || (st.written >= i_cfg.total);
        gath      = st.gather | ({24'd0, i_byte} << {st.byte_idx, 3'b000});
        last_byte = !(({1'b0, st.byte_idx} + 3'd1) < bpp);

        px = gath;
        if (bpp >= 3'd3) begin
            px = {gath[31:24], gath[7:0], gath[15:8], gath[23:16]};
        end
        case (bpp)
            3'd1:    px = {24'd0, px[7:0]};
            3'd2:    px = {16'd0, px[15:0]};
            3'd3:    px = {8'd0, px[23:0]};
            default: px = px;
        endcase

        rep      = 8'd1;
        left_new = st.pkt_left;
        if (i_cfg.rle) begin
            if (st.is_run) begin
                rep      = (st.pkt_left == 8'd0) ? 8'd1 : st.pkt_left;
                left_new = 8'd0;
            end else if (st.pkt_left != 8'd0) begin
                left_new = st.pkt_left - 8'd1;
            end
        end
        // clip the run at the pixels still missing
        remain = i_cfg.total - st.written;
        // the image completes exactly when the run covers what is missing
        done   = ({23'd0, rep} >= remain);
        if ({23'd0, rep} > remain) rep = remain[REP_W-1:0];
        written_new = st.written + {23'd0, rep};

        o_state     = st;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (!blocked) begin
            if (i_cfg.rle && st.in_header) begin
                o_state.is_run    = i_byte[RUN_BIT];
                o_state.pkt_left  = {1'b0, i_byte[6:0] & LEN_MASK} + 8'd1;
                o_state.in_header = 1'b0;
                o_state.gather    = '0;
                o_state.byte_idx  = '0;
            end else if (!last_byte) begin
                o_state.gather   = gath;
                o_state.byte_idx = st.byte_idx + 2'd1;
            end else begin
                o_state.gather   = '0;
                o_state.byte_idx = '0;
                if (i_cfg.rle) begin
                    o_state.pkt_left = left_new;
                    if (left_new == 8'd0) o_state.in_header = 1'b1;
                end
                o_state.written  = written_new;
                o_state.finished = done;
                o_res_valid      = 1'b1;
                o_res.pixel      = px;
                o_res.repeat_res = rep;
                o_res.image_done = done;
            end
        end
    end

endmodule

### hw/rtl/tga_rle_pixel_decoder.sv
// tga run-length pixel decoder
//
// slave stream: one image data byte per transaction in s_tdata[7:0];
// s_tuser marks the first byte of a new image and restarts decoding.
// master stream: one decoded pixel per transaction, tdata[31:0] the pixel
// (first byte low; for 3- and 4-byte pixels red/blue, the first and third bytes, swapped), tdata[39:32]
// its repeat count (1 to 128); tlast flags the pixel that completes the image.
// configuration: write enable, index (0 bytes per pixel, 1 pixel total,
// 2 rle mode) and data, taken at any edge with the enable high; write only
// while no byte is in flight.
// throughput: one byte per cycle while the receiver does not stall. a byte
// completing its pixel passes from the input register through the decode
// logic into the result register.
// header bytes, partial pixel bytes and bytes after the image is complete
// give no result.
// reset (synchronous, active low) clears the pipeline and decoder state and
// loads the register defaults. when the receiver stalls the result register
// holds; a byte that gives no result still moves on, a byte that gives one
// waits in the input register, and s_tready drops.
module tga_rle_pixel_decoder (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [7:0]              i_s_tdata,  // [7:0] data_byte
    input  logic                    i_s_tuser,  // [0] first_byte
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [39:0]             o_m_tdata,  // [31:0] pixel, [39:32] repeat_res
    output logic                    o_m_tlast,  // image_done
    input  logic                    i_cfg_wr_en,
    input  logic [1:0]              i_cfg_idx,
    input  logic [30:0]             i_cfg_data
);
    import tgarle_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    logic    r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    logic    r_s1_first;
    logic    r_o_valid;
    t_result r_o_res;
    t_result n_res;
    logic    n_res_valid;
    logic    adv;

    tgarle_step u_step (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_byte      (r_s1_byte),
        .i_first     (r_s1_first),
        .o_state     (n_state),
        .o_res_valid (n_res_valid),
        .o_res       (n_res)
    );

    // the input stage moves on unless it holds a result with nowhere to go
    assign adv = !r_s1_valid || !n_res_valid || !r_o_valid || i_m_tready;

    assign o_s_tready = adv;
    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {r_o_res.repeat_res, r_o_res.pixel};
    assign o_m_tlast  = r_o_res.image_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= '{bpp: BPP_RESET, total: TOTAL_RESET, rle: RLE_RESET};
            r_state    <= STATE_RESET;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_BPP:   r_cfg.bpp   <= i_cfg_data[BPP_W-1:0];
                    CFG_TOTAL: r_cfg.total <= i_cfg_data;
                    CFG_RLE:   r_cfg.rle   <= i_cfg_data[0];
                    default:   r_cfg       <= r_cfg;
                endcase
            end
            if (adv) begin
                r_s1_valid <= i_s_tvalid;
                if (r_s1_valid) r_state <= n_state;
            end
            if (adv && r_s1_valid && n_res_valid) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_byte  <= i_s_tdata;
            r_s1_first <= i_s_tuser;
        end
        if (adv && r_s1_valid && n_res_valid) begin
            r_o_res <= n_res;
        end
    end

endmodule

### hw/rtl/tgarle_chk.sv
`include "tga_rle_pixel_decoder_assert.svh"

module tgarle_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata,
    input logic        o_m_tlast
);

    // a stalled result keeps its contents
    `TGA_ASSERT_RUN(a_out_hold,
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast),
        "result changed while stalled")

    // repeat count stays within one packet
    `TGA_ASSERT_RUN(a_rep_range,
        o_m_tvalid |-> o_m_tdata[39:32] != 8'd0 && o_m_tdata[39:32] <= 8'd128,
        "repeat count out of range")

    // a new result follows a byte accepted into the input register
    `TGA_ASSERT_RUN(a_rise_src,
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready, 2),
        "result without source byte")

    // reset empties the result register
    `TGA_ASSERT_ALL(a_rst_clear, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

endmodule

bind tga_rle_pixel_decoder tgarle_chk u_chk (.*);
